>>> rtl/ppsc_pkg.sv
// shared types and constants for the pwm period and prescaler calculator
// no dependencies; used by the channel interfaces and the top level
package ppsc_pkg;

  localparam int unsigned FREQ_W   = 32;
  localparam int unsigned DUTY_W   = 7;
  localparam int unsigned SEL_W    = 2;
  localparam int unsigned OUT16_W  = 16;
  localparam int unsigned CMP_W    = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [DUTY_W-1:0]    DUTY_MAX     = 7'd100;
  localparam int unsigned          PCT_DIVISOR  = 100;
  localparam logic [CFG_DAT_W-1:0] CLK_RESET_HZ = 32'd8000000;

  localparam logic [CFG_IDX_W-1:0] REG_BUS1_CLK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUS2_CLK = 2'd1;

  localparam logic [SEL_W-1:0] TIMER_BUS2 = 2'd0;
  localparam logic [SEL_W-1:0] CHAN_EXACT = 2'd0;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_FREQ = 2'd1,
    ST_FREQ_HIGH = 2'd2,
    ST_PSC_OVF   = 2'd3
  } status_t;

  typedef struct packed {
    logic [SEL_W-1:0]  timer_index;
    logic [FREQ_W-1:0] frequency_hz;
    logic [DUTY_W-1:0] duty_percent;
    logic [SEL_W-1:0]  channel;
  } req_t;

  typedef struct packed {
    logic [OUT16_W-1:0] reload;
    logic [OUT16_W-1:0] prescaler;
    logic [CMP_W-1:0]   compare;
    status_t            status;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] value;
  } cfg_t;

endpackage

>>> rtl/ppsc_if.sv
// valid/ready channel interfaces for requests, results and register writes
// depends on ppsc_pkg for the beat payload types
interface ppsc_req_if;
  logic              valid;
  logic              ready;
  ppsc_pkg::req_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppsc_rsp_if;
  logic              valid;
  logic              ready;
  ppsc_pkg::rsp_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppsc_cfg_if;
  logic              valid;
  logic              ready;
  ppsc_pkg::cfg_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/pwm_period_prescaler_calc.sv
// pwm period and prescaler calculator: one request beat gives one result beat
// depends on ppsc_pkg and the channel interfaces in ppsc_if.sv
//
// A request is rejected before any division when its frequency is zero
// or above the clock, stops after the prescaler division when the
// prescaler overflows, and otherwise runs all four. If the previous result
// still waits in the output register, the request also waits until the
// sink takes it. A single restoring divider retires one quotient bit per
// cycle and is shared by the four divisions in turn: clock over frequency,
// ticks over one more than the full reload span, ticks over the prescaler
// plus one, and the duty scaling by 100. One request is worked at a time;
// a new request is taken once the previous result has been moved to the
// output register, which holds it until the sink takes it. Register writes
// are taken at any time.
module pwm_period_prescaler_calc #(
  parameter int unsigned RELOAD_BITS    = 16,
  parameter int unsigned PRESCALER_BITS = 16,
  parameter int unsigned CLOCK_BITS     = 32
) (
  input  logic clk,
  input  logic rst,
  ppsc_req_if.sink   req,
  ppsc_rsp_if.source rsp,
  ppsc_cfg_if.sink   cfg
);

  localparam int unsigned CB    = CLOCK_BITS;
  localparam int unsigned DW    = CB + 7;
  localparam int unsigned CNT_W = $clog2(DW);

  localparam logic [CB:0] PSC_DIV = (RELOAD_BITS >= CB) ?
      {1'b1, {CB{1'b0}}} : (CB+1)'((64'd1 << RELOAD_BITS) + 64'd1);
  localparam logic [CB-1:0] PSC_MAX = (PRESCALER_BITS >= CB) ?
      {CB{1'b1}} : CB'((64'd1 << PRESCALER_BITS) - 64'd1);
  localparam logic [CB:0] PCT_DEN = (CB+1)'(ppsc_pkg::PCT_DIVISOR);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DIV_TICKS, S_DIV_PSC, S_DIV_RELOAD,
    S_MUL_PRE, S_DIV_CMP, S_MUL_POST, S_FINISH
  } state_t;

  state_t state;

  logic [ppsc_pkg::CFG_DAT_W-1:0] bus1_clk;
  logic [ppsc_pkg::CFG_DAT_W-1:0] bus2_clk;

  logic [CB-1:0]                    clk_sel;
  logic [ppsc_pkg::FREQ_W-1:0]      freq;
  logic [ppsc_pkg::DUTY_W-1:0]      duty;
  logic [ppsc_pkg::SEL_W-1:0]       chan;
  logic [CB-1:0]                    ticks;
  logic [CB-1:0]                    psc;
  logic [CB-1:0]                    span;
  logic [ppsc_pkg::CMP_W-1:0]       cmp;
  ppsc_pkg::status_t                status;

  logic [DW-1:0]    div_num;
  logic [CB:0]      div_den;
  logic [CB:0]      div_rem;
  logic [CNT_W-1:0] div_cnt;

  logic              rsp_valid;
  ppsc_pkg::rsp_t    rsp_data;

  // one restoring step per cycle
  logic [CB+1:0] rem_sh;
  logic [CB+2:0] diff;
  logic          qbit;
  logic [CB:0]   rem_step;
  logic [DW-1:0] q_next;
  logic [CB-1:0] q_lo;
  logic          div_last;
  logic [DW-1:0] mul_post;

  assign rem_sh   = {div_rem, div_num[DW-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, div_den};
  assign qbit     = ~diff[CB+2];
  assign rem_step = qbit ? diff[CB:0] : rem_sh[CB:0];
  assign q_next   = {div_num[DW-2:0], qbit};
  assign q_lo     = q_next[CB-1:0];
  assign div_last = (div_cnt == CNT_W'(DW - 1));
  // channels 1 to 3 scale the truncated quotient held in ticks
  assign mul_post = DW'(duty) * DW'(ticks);

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus1_clk <= ppsc_pkg::CLK_RESET_HZ;
      bus2_clk <= ppsc_pkg::CLK_RESET_HZ;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        ppsc_pkg::REG_BUS1_CLK: bus1_clk <= cfg.data.value;
        ppsc_pkg::REG_BUS2_CLK: bus2_clk <= cfg.data.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && state != S_FINISH) begin
        rsp_valid <= 1'b0;
      end
      if ((state == S_DIV_TICKS || state == S_DIV_PSC || state == S_DIV_RELOAD ||
           state == S_DIV_CMP) && !div_last) begin
        div_rem <= rem_step;
        div_num <= q_next;
        div_cnt <= div_cnt + CNT_W'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            clk_sel <= (req.data.timer_index == ppsc_pkg::TIMER_BUS2) ?
                       bus2_clk[CB-1:0] : bus1_clk[CB-1:0];
            freq    <= req.data.frequency_hz;
            duty    <= (req.data.duty_percent > ppsc_pkg::DUTY_MAX) ?
                       ppsc_pkg::DUTY_MAX : req.data.duty_percent;
            chan    <= req.data.channel;
            span    <= '0;
            psc     <= '0;
            cmp     <= '0;
            status  <= ppsc_pkg::ST_OK;
            state   <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (freq == '0) begin
            status <= ppsc_pkg::ST_ZERO_FREQ;
            state  <= S_FINISH;
          end else if (freq > ppsc_pkg::FREQ_W'(clk_sel)) begin
            status <= ppsc_pkg::ST_FREQ_HIGH;
            state  <= S_FINISH;
          end else begin
            div_num <= DW'(clk_sel);
            div_den <= (CB+1)'(freq[CB-1:0]);
            div_rem <= '0;
            div_cnt <= '0;
            state   <= S_DIV_TICKS;
          end
        end
        S_DIV_TICKS: begin
          if (div_last) begin
            ticks   <= q_lo;
            div_num <= DW'(q_lo);
            div_den <= PSC_DIV;
            div_rem <= '0;
            div_cnt <= '0;
            state   <= S_DIV_PSC;
          end
        end
        S_DIV_PSC: begin
          if (div_last) begin
            if (q_lo > PSC_MAX) begin
              status <= ppsc_pkg::ST_PSC_OVF;
              state  <= S_FINISH;
            end else begin
              psc     <= q_lo;
              div_num <= DW'(ticks);
              div_den <= (CB+1)'(q_lo) + (CB+1)'(1);
              div_rem <= '0;
              div_cnt <= '0;
              state   <= S_DIV_RELOAD;
            end
          end
        end
        S_DIV_RELOAD: begin
          if (div_last) begin
            span    <= q_lo;
            div_num <= DW'(q_lo);
            div_den <= PCT_DEN;
            div_rem <= '0;
            div_cnt <= '0;
            state   <= (chan == ppsc_pkg::CHAN_EXACT) ? S_MUL_PRE : S_DIV_CMP;
          end
        end
        S_MUL_PRE: begin
          div_num <= DW'(duty) * DW'(span);
          state   <= S_DIV_CMP;
        end
        S_DIV_CMP: begin
          if (div_last) begin
            if (chan == ppsc_pkg::CHAN_EXACT) begin
              cmp   <= q_next[ppsc_pkg::CMP_W-1:0];
              state <= S_FINISH;
            end else begin
              ticks <= q_lo;
              state <= S_MUL_POST;
            end
          end
        end
        S_MUL_POST: begin
          cmp   <= mul_post[ppsc_pkg::CMP_W-1:0];
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid          <= 1'b1;
            rsp_data.status    <= status;
            rsp_data.prescaler <= psc[ppsc_pkg::OUT16_W-1:0];
            rsp_data.reload    <= (status == ppsc_pkg::ST_OK) ?
                                  span[ppsc_pkg::OUT16_W-1:0] - ppsc_pkg::OUT16_W'(1) :
                                  '0;
            rsp_data.compare   <= cmp;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != ppsc_pkg::ST_OK |->
      rsp_data.reload == '0 && rsp_data.prescaler == '0 && rsp_data.compare == '0)
    else $error("error result carries nonzero fields");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_TICKS || state == S_DIV_PSC || state == S_DIV_RELOAD ||
     state == S_DIV_CMP) |-> div_rem < div_den)
    else $error("divider remainder not below divisor");

  a_span_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV_RELOAD && div_last |-> q_lo != '0)
    else $error("reload span came out zero");

  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == S_CHECK && !req.ready)
    else $error("accepted beat did not start a check");

endmodule
